@@ hdl/assert_macros.svh @@
// Assertion helpers shared by the evaluator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_AT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Flag a condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`endif

@@ hdl/pse_pkg.sv @@
package pse_pkg;

   localparam int DataWidth    = 32;
   localparam int OpWidth      = 3;
   localparam int DepthWidth   = 5;
   localparam int StatusWidth  = 2;
   localparam int DivSteps     = 32;
   localparam int RspDataWidth = 40;

   typedef enum logic [OpWidth-1:0] {
      OP_PUSH = 3'd0,
      OP_ADD  = 3'd1,
      OP_SUB  = 3'd2,
      OP_MUL  = 3'd3,
      OP_DIV  = 3'd4
   } opcode_type;

   typedef enum logic [StatusWidth-1:0] {
      STS_OK      = 2'd0,
      STS_UNDER   = 2'd1,
      STS_OVER    = 2'd2,
      STS_DIVZERO = 2'd3
   } status_type;

   typedef struct packed {
      logic latch;
      logic exec;
      logic start_div;
      logic load_quot;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic need_div;
      logic div_done;
      logic out_free;
   } dp_status_type;

endpackage

@@ hdl/pse_divider.sv @@
module pse_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [pse_pkg::DataWidth-1:0] dividend,
   input  logic [pse_pkg::DataWidth-1:0] divisor,
   output logic                          done,
   output logic [pse_pkg::DataWidth-1:0] quotient
);

   localparam int W    = pse_pkg::DataWidth;
   localparam int CntW = $clog2(pse_pkg::DivSteps + 1);

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [W-1:0]    rem_ff, rem_in;
   logic [W-1:0]    q_ff, q_in;
   logic [W-1:0]    dmag_ff, dmag_in;
   logic            neg_ff, neg_in;

   logic [W:0]      shifted;
   logic [W+1:0]    diff;
   logic            nneg, dneg;

   always_comb begin
      nneg     = dividend[W-1];
      dneg     = divisor[W-1];
      shifted  = {rem_ff, q_ff[W-1]};
      diff     = {1'b0, shifted} - {2'b00, dmag_ff};
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      q_in     = q_ff;
      dmag_in  = dmag_ff;
      neg_in   = neg_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = CntW'(pse_pkg::DivSteps);
         rem_in   = '0;
         q_in     = nneg ? (W'(0) - dividend) : dividend;
         dmag_in  = dneg ? (W'(0) - divisor) : divisor;
         neg_in   = nneg ^ dneg;
      end else if (busy_ff) begin
         if (!diff[W+1]) begin
            rem_in = diff[W-1:0];
            q_in   = {q_ff[W-2:0], 1'b1};
         end else begin
            rem_in = shifted[W-1:0];
            q_in   = {q_ff[W-2:0], 1'b0};
         end
         count_in = count_ff - CntW'(1);
         if (count_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      q_ff    <= q_in;
      dmag_ff <= dmag_in;
      neg_ff  <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (W'(0) - q_ff) : q_ff;

endmodule

@@ hdl/pse_datapath.sv @@
`include "assert_macros.svh"

module pse_datapath #(
   parameter int STACK_DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  pse_pkg::ctrl_cmd_type               cmd,
   output pse_pkg::dp_status_type              sts,
   input  logic [pse_pkg::DataWidth-1:0]       req_tdata,
   input  logic [pse_pkg::OpWidth-1:0]         req_tuser,
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [pse_pkg::RspDataWidth-1:0]    rsp_tdata,
   output logic [pse_pkg::StatusWidth-1:0]     rsp_tuser,
   output logic                                rsp_tlast
);

   localparam int W     = pse_pkg::DataWidth;
   localparam int SpW   = $clog2(STACK_DEPTH + 1);
   localparam int AddrW = $clog2(STACK_DEPTH);
   localparam int DepW  = pse_pkg::DepthWidth;
   localparam int PadW  = pse_pkg::RspDataWidth - W - DepW;

   pse_pkg::opcode_type tok_op_ff, tok_op_in;
   logic [W-1:0]        tok_val_ff, tok_val_in;
   logic                tok_last_ff, tok_last_in;
   logic [SpW-1:0]      sp_ff, sp_in;
   logic [W-1:0]        tos_ff, tos_in;
   logic [W-1:0]        nos_ff;
   logic [W-1:0]        res_ff, res_in;
   pse_pkg::status_type status_ff, status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]        rsp_top_ff, rsp_top_in;
   logic [DepW-1:0]     rsp_depth_ff, rsp_depth_in;
   pse_pkg::status_type rsp_status_ff, rsp_status_in;
   logic                rsp_last_ff, rsp_last_in;

   logic [W-1:0]        stack_mem [STACK_DEPTH];

   pse_pkg::status_type status_c;
   logic [W-1:0]        alu_c;
   logic [SpW-1:0]      sp_new;
   logic [W-1:0]        tos_new;
   logic [31:0]         depth_wide;
   logic [AddrW-1:0]    rd_addr, wr_addr;
   logic                mem_we;
   logic                div_done;
   logic [W-1:0]        quotient;
   logic                out_free;
   logic                err_commit;

   assign rd_addr  = AddrW'(sp_ff - SpW'(2));
   assign wr_addr  = AddrW'(sp_ff - SpW'(1));
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      status_c = pse_pkg::STS_OK;
      case (tok_op_ff) inside
         pse_pkg::OP_PUSH: begin
            if (sp_ff == SpW'(STACK_DEPTH)) begin
               status_c = pse_pkg::STS_OVER;
            end
         end
         pse_pkg::OP_ADD, pse_pkg::OP_SUB, pse_pkg::OP_MUL: begin
            if (sp_ff < SpW'(2)) begin
               status_c = pse_pkg::STS_UNDER;
            end
         end
         pse_pkg::OP_DIV: begin
            if (sp_ff < SpW'(2)) begin
               status_c = pse_pkg::STS_UNDER;
            end else if (tos_ff == '0) begin
               status_c = pse_pkg::STS_DIVZERO;
            end
         end
         default: status_c = pse_pkg::STS_OK;
      endcase
   end

   always_comb begin
      case (tok_op_ff)
         pse_pkg::OP_ADD: alu_c = nos_ff + tos_ff;
         pse_pkg::OP_SUB: alu_c = nos_ff - tos_ff;
         pse_pkg::OP_MUL: alu_c = nos_ff * tos_ff;
         default:         alu_c = '0;
      endcase
   end

   always_comb begin
      sp_new  = sp_ff;
      tos_new = tos_ff;
      mem_we  = 1'b0;
      if (status_ff == pse_pkg::STS_OK) begin
         case (tok_op_ff) inside
            pse_pkg::OP_PUSH: begin
               sp_new  = sp_ff + SpW'(1);
               tos_new = tok_val_ff;
               mem_we  = cmd.commit && (sp_ff != '0);
            end
            pse_pkg::OP_ADD, pse_pkg::OP_SUB, pse_pkg::OP_MUL, pse_pkg::OP_DIV: begin
               sp_new  = sp_ff - SpW'(1);
               tos_new = res_ff;
            end
            default: begin
               sp_new  = sp_ff;
               tos_new = tos_ff;
            end
         endcase
      end
      depth_wide = 32'(sp_new);
   end

   always_comb begin
      tok_op_in     = tok_op_ff;
      tok_val_in    = tok_val_ff;
      tok_last_in   = tok_last_ff;
      sp_in         = sp_ff;
      tos_in        = tos_ff;
      res_in        = res_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_top_in    = rsp_top_ff;
      rsp_depth_in  = rsp_depth_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      if (cmd.latch) begin
         tok_op_in   = pse_pkg::opcode_type'(req_tuser);
         tok_val_in  = req_tdata;
         tok_last_in = req_tlast;
      end
      if (cmd.exec) begin
         res_in    = alu_c;
         status_in = status_c;
      end
      if (cmd.load_quot) begin
         res_in = quotient;
      end
      if (cmd.commit) begin
         sp_in         = tok_last_ff ? '0 : sp_new;
         tos_in        = tos_new;
         rsp_valid_in  = 1'b1;
         rsp_top_in    = (sp_new != '0) ? tos_new : '0;
         rsp_depth_in  = depth_wide[DepW-1:0];
         rsp_status_in = status_ff;
         rsp_last_in   = tok_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sp_ff        <= sp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tok_op_ff     <= tok_op_in;
      tok_val_ff    <= tok_val_in;
      tok_last_ff   <= tok_last_in;
      tos_ff        <= tos_in;
      res_ff        <= res_in;
      status_ff     <= status_in;
      rsp_top_ff    <= rsp_top_in;
      rsp_depth_ff  <= rsp_depth_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      nos_ff <= stack_mem[rd_addr];
      if (mem_we) begin
         stack_mem[wr_addr] <= tos_ff;
      end
   end

   pse_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.start_div),
      .dividend (nos_ff),
      .divisor  (tos_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   assign sts.need_div = (tok_op_ff == pse_pkg::OP_DIV) && (status_c == pse_pkg::STS_OK);
   assign sts.div_done = div_done;
   assign sts.out_free = out_free;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PadW{1'b0}}, rsp_depth_ff, rsp_top_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign err_commit = cmd.commit && !tok_last_ff && (status_ff != pse_pkg::STS_OK);

   `ASSERT_NEVER(a_sp_bound, clock, reset, sp_ff > SpW'(STACK_DEPTH))
   `ASSERT_AT(a_last_clears, clock, reset, (cmd.commit && tok_last_ff) |=> (sp_ff == '0))
   `ASSERT_AT(a_err_holds, clock, reset, err_commit |=> ($stable(sp_ff) && $stable(tos_ff)))

endmodule

@@ hdl/pse_ctrl.sv @@
`include "assert_macros.svh"

module pse_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  pse_pkg::dp_status_type sts,
   output pse_pkg::ctrl_cmd_type  cmd
);

   typedef enum logic [2:0] {
      IDLE,
      LOAD,
      EXEC,
      DIVIDE,
      FINISH
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         IDLE: begin
            if (req_tvalid) begin
               cmd.latch = 1'b1;
               state_in  = LOAD;
            end
         end
         LOAD: begin
            state_in = EXEC;
         end
         EXEC: begin
            cmd.exec = 1'b1;
            if (sts.need_div) begin
               cmd.start_div = 1'b1;
               state_in      = DIVIDE;
            end else begin
               state_in = FINISH;
            end
         end
         DIVIDE: begin
            if (sts.div_done) begin
               cmd.load_quot = 1'b1;
               state_in      = FINISH;
            end
         end
         FINISH: begin
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == IDLE);

   `ASSERT_AT(a_div_wait, clock, reset, ((state_ff == DIVIDE) && !sts.div_done) |=> (state_ff == DIVIDE))

endmodule

@@ hdl/postfix_stack_evaluator_core.sv @@
// Postfix evaluator: each token transfer on the req_ channel (push, add, subtract, multiply,
// divide in req_tuser, the pushed value in req_tdata, end of expression on req_tlast) gives
// exactly one transfer on the rsp_ channel with the new top of stack, the depth and a status;
// on any error the stack is left as it was, and a token with req_tlast set empties the stack
// after its result. Tokens are handled one at a time through the load, execute and finish
// states; a divide with two operands and a nonzero divisor also waits in the divide state
// for the restoring divider, which resolves one quotient bit per cycle over 32 steps.
// The result register lets the next token in while a result is still waiting.
module postfix_stack_evaluator_core #(
   parameter int STACK_DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [pse_pkg::DataWidth-1:0]    req_tdata,   // [31:0] operand_value
   input  logic [pse_pkg::OpWidth-1:0]      req_tuser,   // [2:0] opcode
   input  logic                             req_tlast,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [pse_pkg::RspDataWidth-1:0] rsp_tdata,   // [31:0] top_value, [36:32] stack_depth
   output logic [pse_pkg::StatusWidth-1:0]  rsp_tuser,   // [1:0] status
   output logic                             rsp_tlast
);

   pse_pkg::ctrl_cmd_type  cmd;
   pse_pkg::dp_status_type sts;

   pse_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   pse_datapath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
